// ===== hdl/btc_pkg.sv =====
`default_nettype none

package btc_pkg;

  // Width of the press and idle tick counters.
  localparam int COUNT_WIDTH = 16;

  // Width of the configuration registers and of the configuration data.
  localparam int CFG_W = 16;

  // Compare width that covers both a counter and a configuration register.
  localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

  // Number of short taps that resolves at once as a multi tap.
  localparam logic [1:0] TAP_BURST = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] HOLD_TICKS_RST  = CFG_W'(300);
  localparam logic [CFG_W-1:0] TAP_TIMEOUT_RST = CFG_W'(50);

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_HOLD_TICKS  = 1'b0,
    CFG_TAP_TIMEOUT = 1'b1
  } cfg_reg_t;

  // Event codes of a result item.
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_HOLD   = 2'd1,
    EV_SINGLE = 2'd2,
    EV_MULTI  = 2'd3
  } event_t;

  // Current configuration, as seen by the classifier.
  typedef struct packed {
    logic [CFG_W-1:0] hold_ticks;
    logic [CFG_W-1:0] tap_timeout_ticks;
  } btc_cfg_t;

  // Result of one tick.
  typedef struct packed {
    logic [1:0] event_res;
    logic [1:0] taps_pending;
  } btc_result_t;

endpackage

`default_nettype wire

// ===== hdl/btc_if.sv =====
`default_nettype none

// Channel of poll ticks.
interface btc_tick_if;
  logic valid;
  logic ready;
  logic pressed;

  modport source (output valid, output pressed, input ready);
  modport sink (input valid, input pressed, output ready);
endinterface

// Channel of classified results.
interface btc_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [1:0] taps_pending;

  modport source (output valid, output event_res, output taps_pending, input ready);
  modport sink (input valid, input event_res, input taps_pending, output ready);
endinterface

// Configuration write channel.
interface btc_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/btc_cfg_regs.sv =====
`default_nettype none

module btc_cfg_regs
  import btc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [0:0]       wr_index,
  input  wire logic [CFG_W-1:0] wr_data,
  output btc_cfg_t              cfg
);

  // Register file of the two thresholds, written by index.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_ticks        <= HOLD_TICKS_RST;
      cfg.tap_timeout_ticks <= TAP_TIMEOUT_RST;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        CFG_HOLD_TICKS:  cfg.hold_ticks        <= wr_data;
        CFG_TAP_TIMEOUT: cfg.tap_timeout_ticks <= wr_data;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/btc_core.sv =====
`default_nettype none

module btc_core
  import btc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      step,
  input  wire logic      pressed,
  input  wire btc_cfg_t  cfg,
  output btc_result_t    result
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic                   was_pressed;
  logic [COUNT_WIDTH-1:0] press_len;
  logic [1:0]             tap_count;
  logic [COUNT_WIDTH-1:0] idle_len;

  logic                   was_pressed_next;
  logic [COUNT_WIDTH-1:0] press_len_next;
  logic [1:0]             tap_count_next;
  logic [COUNT_WIDTH-1:0] idle_len_next;

  logic [COUNT_WIDTH-1:0] press_inc;
  logic [COUNT_WIDTH-1:0] idle_inc;
  logic [1:0]             tap_inc;
  logic                   is_hold;
  logic                   timed_out;
  event_t                 ev;

  // Saturating press and idle increments, the tap increment and threshold compares.
  assign press_inc = (press_len == CNT_MAX) ? CNT_MAX : press_len + COUNT_WIDTH'(1);
  assign idle_inc  = (idle_len == CNT_MAX) ? CNT_MAX : idle_len + COUNT_WIDTH'(1);
  assign tap_inc   = tap_count + 2'd1;
  assign is_hold   = CMP_W'(press_len) >= CMP_W'(cfg.hold_ticks);
  assign timed_out = CMP_W'(idle_inc) > CMP_W'(cfg.tap_timeout_ticks);

  // Classification of one tick.
  always_comb begin
    was_pressed_next = pressed;
    press_len_next   = press_len;
    tap_count_next   = tap_count;
    idle_len_next    = idle_len;
    ev               = EV_NONE;
    if (pressed) begin
      press_len_next = was_pressed ? press_inc : COUNT_WIDTH'(1);
    end else if (was_pressed) begin
      // Release: classify the press just ended.
      if (is_hold) begin
        ev             = EV_HOLD;
        tap_count_next = 2'd0;
      end else if (tap_inc >= TAP_BURST) begin
        ev             = EV_MULTI;
        tap_count_next = 2'd0;
      end else begin
        tap_count_next = tap_inc;
      end
      press_len_next = '0;
      idle_len_next  = '0;
    end else if (tap_count != 2'd0) begin
      // Idle with taps pending: count toward the timeout.
      idle_len_next = idle_inc;
      if (timed_out) begin
        ev             = (tap_count == 2'd1) ? EV_SINGLE : EV_MULTI;
        tap_count_next = 2'd0;
        idle_len_next  = '0;
      end
    end
  end

  assign result.event_res    = ev;
  assign result.taps_pending = tap_count_next;

  // Tracking state, advanced once per tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      was_pressed <= 1'b0;
      press_len   <= '0;
      tap_count   <= 2'd0;
      idle_len    <= '0;
    end else if (step) begin
      was_pressed <= was_pressed_next;
      press_len   <= press_len_next;
      tap_count   <= tap_count_next;
      idle_len    <= idle_len_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/button_tap_hold_classifier.sv =====
`default_nettype none

// Button tap and hold classifier.
// The tick channel carries one sampled button level per poll tick. For every
// tick item the result channel returns exactly one item: an event code (none,
// long hold, single tap, multi tap) and the number of short taps still
// pending after that tick.
// Each tick item is held in an input register; the classifier works on it
// and its result is loaded into the output register, which offers it on the
// result channel. Throughput is one item per clock cycle unless the receiver
// stalls; the press, idle and tap counters and their compares are the only
// logic between the two registers.
// The cfg channel writes hold_ticks (index 0) and tap_timeout_ticks (index 1);
// it is always ready and is meant to be used while no tick is in flight.
// Reset clears the valid flags of both registers, the tap and counter state,
// and loads the default thresholds of 300 and 50 ticks.
// When the receiver stalls, the output register holds its item and the input
// register accepts one more tick; after that the tick channel stalls too.
module button_tap_hold_classifier
  import btc_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  btc_tick_if.sink      tick,
  btc_result_if.source  result,
  btc_cfg_if.sink       cfg
);

  logic        in_valid;
  logic        in_pressed;
  logic        out_valid;
  btc_result_t out_res;
  logic        advance;
  btc_cfg_t    cfg_regs;
  btc_result_t core_res;

  // The held tick moves on when the output register is free or drains.
  assign advance    = in_valid && (!out_valid || result.ready);
  assign tick.ready = !in_valid || advance;
  assign cfg.ready  = 1'b1;

  btc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_regs)
  );

  btc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .pressed (in_pressed),
    .cfg     (cfg_regs),
    .result  (core_res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.valid && tick.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      in_pressed <= tick.pressed;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign result.valid        = out_valid;
  assign result.event_res    = out_res.event_res;
  assign result.taps_pending = out_res.taps_pending;

endmodule

`default_nettype wire

// ===== dv/button_tap_hold_classifier_tb.sv =====
`timescale 1ns / 100ps

module button_tap_hold_classifier_tb
  import btc_pkg::*;
();

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = '1;

  logic clk;
  logic rst;

  btc_tick_if   tick_ch ();
  btc_result_if res_ch ();
  btc_cfg_if    cfg_ch ();

  button_tap_hold_classifier dut (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  // Predicted results, oldest first.
  btc_result_t results_due[$];

  // Clock and cycle watchdog.
  initial clk = 1'b0;
  always #1 clk = ~clk;

  int unsigned cycles;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycles, results_due.size());
      $display("button_tap_hold_classifier_tb: errors");
      $finish;
    end
  end

  // Predicted state of the classifier and its current thresholds.
  logic                   was_down;
  logic [COUNT_WIDTH-1:0] press_ticks;
  logic [COUNT_WIDTH-1:0] idle_ticks;
  logic [1:0]             taps;
  logic [CFG_W-1:0]       hold_limit;
  logic [CFG_W-1:0]       idle_limit;

  int unsigned err_count;
  int unsigned ticks_sent;
  int unsigned settings_used;
  int unsigned holds_seen;
  int unsigned singles_seen;
  int unsigned multis_seen;

  bit tick_steady;
  bit sink_steady;
  bit all_steady;

  function automatic logic [COUNT_WIDTH-1:0] sat_step(logic [COUNT_WIDTH-1:0] v);
    return (v == COUNT_TOP) ? COUNT_TOP : v + COUNT_WIDTH'(1);
  endfunction

  // Advances the predicted state by one poll tick and returns its result.
  function automatic btc_result_t classify_tick(logic down);
    event_t      ev;
    btc_result_t r;
    ev = EV_NONE;
    if (down) begin
      press_ticks = was_down ? sat_step(press_ticks) : COUNT_WIDTH'(1);
    end else if (was_down) begin
      if (press_ticks >= hold_limit) begin
        ev   = EV_HOLD;
        taps = 2'd0;
      end else begin
        taps = taps + 2'd1;
        if (taps >= TAP_BURST) begin
          ev   = EV_MULTI;
          taps = 2'd0;
        end
      end
      press_ticks = '0;
      idle_ticks  = '0;
    end else if (taps != 2'd0) begin
      idle_ticks = sat_step(idle_ticks);
      if (idle_ticks > idle_limit) begin
        ev         = (taps == 2'd1) ? EV_SINGLE : EV_MULTI;
        taps       = 2'd0;
        idle_ticks = '0;
      end
    end
    was_down       = down;
    r.event_res    = ev;
    r.taps_pending = taps;
    return r;
  endfunction

  // Track register writes and accepted ticks.
  always @(posedge clk) begin
    if (rst) begin
      was_down    = 1'b0;
      press_ticks = '0;
      idle_ticks  = '0;
      taps        = 2'd0;
      hold_limit  = HOLD_TICKS_RST;
      idle_limit  = TAP_TIMEOUT_RST;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_reg_t'(cfg_ch.index))
          CFG_HOLD_TICKS:  hold_limit = cfg_ch.data;
          CFG_TAP_TIMEOUT: idle_limit = cfg_ch.data;
          default: ;
        endcase
      end
      if (tick_ch.valid && tick_ch.ready)
        results_due.push_back(classify_tick(tick_ch.pressed));
    end
  end

  // Compare each accepted result item with the oldest prediction.
  always @(posedge clk) begin
    btc_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      case (event_t'(res_ch.event_res))
        EV_HOLD:   holds_seen++;
        EV_SINGLE: singles_seen++;
        EV_MULTI:  multis_seen++;
        default: ;
      endcase
      if (results_due.size() == 0) begin
        $error("result item with no tick outstanding: event_res %0d taps_pending %0d",
               res_ch.event_res, res_ch.taps_pending);
        err_count++;
      end else begin
        want = results_due.pop_front();
        if (res_ch.event_res !== want.event_res) begin
          $error("event_res expected %0d actual %0d", want.event_res, res_ch.event_res);
          err_count++;
        end
        if (res_ch.taps_pending !== want.taps_pending) begin
          $error("taps_pending expected %0d actual %0d",
                 want.taps_pending, res_ch.taps_pending);
          err_count++;
        end
      end
    end
  end

  function automatic int pick_gap(bit steady);
    return steady ? 0 : $urandom_range(0, 8);
  endfunction

  // Result receiver: random stalls, with stretches of none.
  initial begin
    int n;
    forever begin
      if ($urandom_range(0, 47) == 0)
        sink_steady = !sink_steady;
      n = pick_gap(sink_steady || all_steady);
      if (n > 0) begin
        res_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
    end
  end

  // Send one tick item; valid stays high if the next item follows at once.
  task automatic send_tick(input logic level);
    int n;
    n = pick_gap(tick_steady || all_steady);
    if (n > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    tick_ch.valid   <= 1'b1;
    tick_ch.pressed <= level;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic drive_level(input logic level, input int count);
    repeat (count) send_tick(level);
  endtask

  task automatic gesture(input int down_count, input int up_count);
    drive_level(1'b1, down_count);
    drive_level(1'b0, up_count);
  endtask

  task automatic tick_quiet();
    tick_ch.valid <= 1'b0;
  endtask

  // Write both thresholds once every predicted result has come back.
  task automatic write_cfg(input logic [CFG_W-1:0] hold_val,
                           input logic [CFG_W-1:0] timeout_val);
    tick_quiet();
    do @(posedge clk); while (results_due.size() != 0);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_HOLD_TICKS;
    cfg_ch.data  <= hold_val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.index <= CFG_TAP_TIMEOUT;
    cfg_ch.data  <= timeout_val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // Reset thresholds: a press one short of the hold limit is a tap, one at
  // the limit is a hold, and a tap resolves on the first idle tick past 50.
  task automatic test_reset_values();
    all_steady = 1'b1;
    gesture(300, 1);
    gesture(299, 50);
    drive_level(1'b0, 2);
    all_steady = 1'b0;
  endtask

  // A lone tap resolves as a single tap once the timeout passes.
  task automatic test_single_tap();
    write_cfg(16'd3, 16'd1);
    gesture(1, 3);
  endtask

  // Two taps with a press in between: idle counting pauses and restarts.
  task automatic test_double_tap();
    gesture(2, 2);
    gesture(1, 3);
  endtask

  // The third tap resolves as a multi tap on its own release.
  task automatic test_triple_tap();
    gesture(1, 1);
    gesture(1, 1);
    gesture(1, 2);
  endtask

  // A long press clears a pending tap.
  task automatic test_long_hold();
    gesture(1, 1);
    gesture(3, 2);
  endtask

  // Zero thresholds: with both at zero every press is a hold, and with a zero
  // timeout a tap resolves on the first idle tick.
  task automatic test_zero_registers();
    write_cfg(16'd0, 16'd0);
    gesture(1, 1);
    write_cfg(16'd3, 16'd0);
    gesture(1, 2);
  endtask

  // Top thresholds: presses stay taps, idle stretches never resolve them,
  // and the third tap gives a multi tap.
  task automatic test_top_thresholds();
    write_cfg(16'hFFFF, 16'hFFFF);
    gesture(6, 20);
    gesture(4, 20);
    gesture(2, 3);
  endtask

  function automatic int pick_len(logic [CFG_W-1:0] limit);
    return (limit <= 40) ? $urandom_range(1, int'(limit) + 3) : $urandom_range(1, 12);
  endfunction

  // Mostly well-formed press and release sequences, around the thresholds
  // when they are at most 40, with some random level noise mixed in.
  task automatic run_random_phase(input logic [CFG_W-1:0] hold_val,
                                  input logic [CFG_W-1:0] timeout_val,
                                  input int count);
    int stop_at;
    write_cfg(hold_val, timeout_val);
    tick_steady = ($urandom_range(0, 3) == 0);
    stop_at = ticks_sent + count;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(0, 6) == 0)
        drive_level(logic'($urandom_range(0, 1)), $urandom_range(1, 3));
      else
        gesture(pick_len(hold_val), pick_len(timeout_val));
      if ($urandom_range(0, 31) == 0)
        tick_steady = !tick_steady;
    end
    tick_steady = 1'b0;
  endtask

  task automatic test_random();
    run_random_phase(CFG_W'($urandom_range(1, 12)), CFG_W'($urandom_range(1, 12)), 60);
    run_random_phase(CFG_W'($urandom_range(1, 12)), CFG_W'($urandom_range(1, 12)), 60);
    run_random_phase(16'd1, 16'd1, 60);
    run_random_phase(16'hFFFF, 16'hFFFF, 60);
    run_random_phase(CFG_W'($urandom_range(1, 12)), 16'hFFFF, 60);
    run_random_phase(16'hFFFF, CFG_W'($urandom_range(1, 12)), 60);
    run_random_phase(CFG_W'($urandom_range(1, 65535)),
                     CFG_W'($urandom_range(1, 65535)), 60);
    run_random_phase(CFG_W'($urandom_range(1, 20)), CFG_W'($urandom_range(1, 20)), 60);
  endtask

  // Test sequence.
  initial begin
    rst             <= 1'b1;
    tick_ch.valid   <= 1'b0;
    tick_ch.pressed <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= CFG_HOLD_TICKS;
    cfg_ch.data     <= '0;
    settings_used   = 1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_single_tap();
    test_double_tap();
    test_triple_tap();
    test_long_hold();
    test_zero_registers();
    test_top_thresholds();
    test_random();

    // Drain the last results, then watch for stray items.
    tick_quiet();
    do @(posedge clk); while (results_due.size() != 0);
    repeat (4) @(posedge clk);

    $display("Sent %0d ticks under %0d threshold settings, from zero to the top of the range.",
             ticks_sent, settings_used);
    $display("Results seen: %0d long holds, %0d single taps, %0d multi taps.",
             holds_seen, singles_seen, multis_seen);
    if (err_count == 0) begin
      $display("button_tap_hold_classifier_tb: clean");
    end else begin
      $display("button_tap_hold_classifier_tb: errors");
    end
    $finish;
  end

endmodule

// ===== button_tap_hold_classifier.f =====
hdl/btc_pkg.sv
hdl/btc_if.sv
hdl/btc_cfg_regs.sv
hdl/btc_core.sv
hdl/button_tap_hold_classifier.sv
dv/button_tap_hold_classifier_tb.sv
